// File: sv/tero_pkg.sv
// Shared types and constants for the thresholded 3x3 erosion block.
// No dependencies; used by tero_min_tree, tero_limit and thresholded_erosion_3x3.

package tero_pkg;

  // Fixed widths of the stream fields and config registers
  localparam int FIELD_BITS         = 16;
  localparam int WINDOW_PIXELS      = 9;
  localparam int CENTRE_IDX         = 4;
  localparam int DEV_BITS           = 16;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int CFG_DATA_BITS      = 16;
  localparam int PIXEL_BITS_DEFAULT = 16;

  localparam logic [DEV_BITS-1:0] MAX_DEVIATION_RESET = '1;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_ROW    = 2'd1,
    SHAPE_COLUMN = 2'd2,
    SHAPE_CROSS  = 2'd3
  } shape_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_SHAPE  = 1'b0,
    REG_MAX_DEVIATION = 1'b1
  } reg_index_t;

endpackage

// File: sv/thresholded_erosion_3x3.sv
// Top level of the thresholded 3x3 grayscale erosion block.
// Depends on tero_pkg, tero_min_tree and tero_limit.

// Thresholded 3x3 erosion. Each input word carries one 3x3 window of pixels;
// each output word carries the eroded centre pixel: the minimum over the
// neighbors picked by window_shape (square, row of three, column of three or
// plus cross; the centre always counts), raised to centre - max_deviation when
// the minimum lies further below the centre than that. The pipeline takes one
// window per clock and has four register stages (stage 1 shape select and
// first compares, loaded at the accepting edge; stage 2 second compares;
// stage 3 final minimum; stage 4 deviation limit into the output register).
// Each stage has its own valid bit and moves whenever it is empty or its
// successor moves, so bubbles close up and new windows keep entering while a
// finished result waits for m_tready; throughput drops below one per clock
// only while the sink holds m_tready low with all four stages full. Only the
// low PIXEL_BITS bits of each pixel are used and the result is zero-extended
// to 16 bits. Configuration (cfg_index 0: window_shape, 1: max_deviation)
// must be written by the user only while the pipeline is empty; the block
// itself does not enforce this. Reset gives the square shape and a deviation
// of 65535, which never limits. No memories, no clearing pass after reset.

module thresholded_erosion_3x3 #(
  parameter int PIXEL_BITS = tero_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // window in: tdata from bit 0 up, 16 bits each: top_left, top_mid,
  // top_right, mid_left, centre_pixel, mid_right, bottom_left, bottom_mid,
  // bottom_right
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tero_pkg::WINDOW_PIXELS*tero_pkg::FIELD_BITS-1:0] s_tdata,
  // result out: tdata bits 15:0 eroded_pixel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tero_pkg::FIELD_BITS-1:0]     m_tdata,
  // config write port
  input  logic                                cfg_we,
  input  logic [tero_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tero_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  tero_pkg::shape_t              window_shape;
  logic [tero_pkg::DEV_BITS-1:0] max_deviation;

  logic [PIXEL_BITS-1:0] pix [tero_pkg::WINDOW_PIXELS];

  logic                  tree_valid;
  logic                  tree_ready;
  logic [PIXEL_BITS-1:0] tree_min;
  logic [PIXEL_BITS-1:0] tree_centre;
  logic [PIXEL_BITS-1:0] eroded;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_shape  <= tero_pkg::SHAPE_SQUARE;
      max_deviation <= tero_pkg::MAX_DEVIATION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tero_pkg::REG_WINDOW_SHAPE:  window_shape  <= tero_pkg::shape_t'(cfg_data[1:0]);
        tero_pkg::REG_MAX_DEVIATION: max_deviation <= cfg_data[tero_pkg::DEV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // unpack the window, keeping only the low pixel bits of each field
  always_comb begin
    for (int i = 0; i < tero_pkg::WINDOW_PIXELS; i++) begin
      pix[i] = s_tdata[i*tero_pkg::FIELD_BITS +: PIXEL_BITS];
    end
  end

  // stages 1-3: shape select and minimum
  tero_min_tree #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_min_tree (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pix        (pix),
    .shape      (window_shape),
    .out_valid  (tree_valid),
    .out_ready  (tree_ready),
    .out_min    (tree_min),
    .out_centre (tree_centre)
  );

  // stage 4: deviation limit and output register
  tero_limit #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_limit (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (tree_valid),
    .in_ready      (tree_ready),
    .in_min        (tree_min),
    .in_centre     (tree_centre),
    .max_deviation (max_deviation),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_pixel     (eroded)
  );

  assign m_tdata = tero_pkg::FIELD_BITS'(eroded);

endmodule

// File: sv/tero_min_tree.sv
// Three-stage minimum tree over the shape-selected 3x3 neighborhood.
// Depends on tero_pkg (shape codes, window constants).

module tero_min_tree #(
  parameter int PIXEL_BITS = tero_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pix [tero_pkg::WINDOW_PIXELS],
  input  tero_pkg::shape_t      shape,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_min,
  output logic [PIXEL_BITS-1:0] out_centre
);

  function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    return (b < a) ? b : a;
  endfunction

  logic [tero_pkg::WINDOW_PIXELS-1:0] use_nb;
  logic [PIXEL_BITS-1:0]              q [tero_pkg::WINDOW_PIXELS];

  logic                  s1_valid;
  logic                  s1_ready;
  logic [PIXEL_BITS-1:0] s1_min [4];
  logic [PIXEL_BITS-1:0] s1_centre;

  logic                  s2_valid;
  logic                  s2_ready;
  logic [PIXEL_BITS-1:0] s2_min [2];
  logic [PIXEL_BITS-1:0] s2_centre;

  logic                  s3_ready;

  // Neighbors outside the shape read as all ones so they never win.
  always_comb begin
    use_nb = '0;
    case (shape)
      tero_pkg::SHAPE_SQUARE: use_nb = '1;
      tero_pkg::SHAPE_ROW: begin
        use_nb[3] = 1'b1;
        use_nb[5] = 1'b1;
      end
      tero_pkg::SHAPE_COLUMN: begin
        use_nb[1] = 1'b1;
        use_nb[7] = 1'b1;
      end
      tero_pkg::SHAPE_CROSS: begin
        use_nb[1] = 1'b1;
        use_nb[3] = 1'b1;
        use_nb[5] = 1'b1;
        use_nb[7] = 1'b1;
      end
      default: use_nb = '1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < tero_pkg::WINDOW_PIXELS; i++) begin
      q[i] = use_nb[i] ? pix[i] : '1;
    end
  end

  // Per-stage ready: a stage moves when empty or when the next one moves
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_min[0] <= min2(q[0], q[1]);
      s1_min[1] <= min2(q[2], q[3]);
      s1_min[2] <= min2(q[5], q[6]);
      s1_min[3] <= min2(q[7], q[8]);
      s1_centre <= pix[tero_pkg::CENTRE_IDX];
    end
    if (s2_ready && s1_valid) begin
      s2_min[0] <= min2(s1_min[0], s1_min[1]);
      s2_min[1] <= min2(s1_min[2], s1_min[3]);
      s2_centre <= s1_centre;
    end
    if (s3_ready && s2_valid) begin
      out_min    <= min2(min2(s2_min[0], s2_min[1]), s2_centre);
      out_centre <= s2_centre;
    end
  end

  // centre is in every set, so the minimum can never exceed it
  a_min_le_centre: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_min <= out_centre)
    else $error("min tree result above centre pixel");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted window lost at stage 1");

endmodule

// File: sv/tero_limit.sv
// Deviation limit stage and output register of the erosion pipeline.
// Depends on tero_pkg (deviation register width).

module tero_limit #(
  parameter int PIXEL_BITS = tero_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PIXEL_BITS-1:0]         in_min,
  input  logic [PIXEL_BITS-1:0]         in_centre,
  input  logic [tero_pkg::DEV_BITS-1:0] max_deviation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PIXEL_BITS-1:0]         out_pixel
);

  logic [PIXEL_BITS-1:0] drop;
  logic [PIXEL_BITS-1:0] floor_pix;
  logic                  too_deep;
  logic [PIXEL_BITS-1:0] result;

  // min <= centre, so drop never wraps. floor_pix is only picked when
  // max_deviation < drop, i.e. when it fits in the pixel width.
  assign drop      = in_centre - in_min;
  assign too_deep  = tero_pkg::DEV_BITS'(drop) > max_deviation;
  assign floor_pix = in_centre - max_deviation[PIXEL_BITS-1:0];
  assign result    = too_deep ? floor_pix : in_min;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pixel <= result;
    end
  end

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_valid && in_ready) |=>
      (out_pixel >= $past(in_min) && out_pixel <= $past(in_centre)))
    else $error("limited pixel outside [min, centre]");

  a_no_limit_small_drop: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_valid && in_ready && !too_deep) |=> out_pixel == $past(in_min))
    else $error("result limited although drop within deviation");

endmodule
